// File: src/particle_attractor_step_core_assert.svh
// Assertion macros shared by the checker
`ifndef PARTICLE_ATTRACTOR_STEP_CORE_ASSERT_SVH
`define PARTICLE_ATTRACTOR_STEP_CORE_ASSERT_SVH
// same-cycle implication, masked during reset
`define PAS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, masked during reset
`define PAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
// next-cycle implication, live through reset
`define PAS_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: src/pas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pas_pkg;
    localparam int POS_W     = 32;
    localparam int DT_W      = 16;
    localparam int GAIN_W    = 20;
    localparam int SOFT_W    = 16;
    localparam int DAMP_W    = 16;
    localparam int CUR_W     = 16;
    localparam int LIFE_W    = 16;
    localparam int DIFF_W    = 34;
    localparam int MAG_W     = 32;
    localparam int GDT_W     = GAIN_W + DT_W;
    localparam int SQ_W      = 64;
    localparam int NUM_W     = GDT_W + MAG_W;
    localparam int DIV_STEPS = 41;
    localparam int Q_W       = DIV_STEPS;
    localparam int TOP_W     = NUM_W - DIV_STEPS;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(500000);
    localparam logic [SOFT_W-1:0] SOFT_RST = SOFT_W'(100);
    localparam logic [DAMP_W-1:0] DAMP_RST = DAMP_W'(64881);

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_ATTRACT = 2'd1,
        MODE_REPEL   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        REG_GAIN = 2'd0,
        REG_SOFT = 2'd1,
        REG_DAMP = 2'd2
    } t_reg;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [SOFT_W-1:0] soften;
        logic [DAMP_W-1:0] damp;
    } t_cfg;

    typedef struct packed {
        logic              active_in;
        logic [LIFE_W-1:0] life_left;
        logic [POS_W-1:0]  pos_x_in;
        logic [POS_W-1:0]  pos_y_in;
        logic [POS_W-1:0]  vel_x_in;
        logic [POS_W-1:0]  vel_y_in;
        logic [CUR_W-1:0]  cursor_x;
        logic [CUR_W-1:0]  cursor_y;
        logic [1:0]        force_mode;
        logic [DT_W-1:0]   time_step;
        logic              last_particle;
    } t_item;

    typedef struct packed {
        logic             live;
        logic             clr;
        logic             frc;
        logic             sub;
        logic             last;
        logic             sgnx;
        logic             sgny;
        logic [DT_W-1:0]  dt;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [POS_W-1:0] vx;
        logic [POS_W-1:0] vy;
    } t_side;

    typedef struct packed {
        t_side             side;
        logic [SQ_W-1:0]   den;
        logic [NUM_W-1:0]  nx;
        logic [NUM_W-1:0]  ny;
    } t_front;

    typedef struct packed {
        logic             active_out;
        logic             clear_alpha;
        logic [POS_W-1:0] pos_x_out;
        logic [POS_W-1:0] pos_y_out;
        logic [POS_W-1:0] vel_x_out;
        logic [POS_W-1:0] vel_y_out;
        logic             last_out;
    } t_result;
endpackage
`default_nettype wire

// File: src/pas_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pas_in_if;
    import pas_pkg::*;
    logic              valid;
    logic              ready;
    logic              active_in;
    logic [LIFE_W-1:0] life_left;
    logic [POS_W-1:0]  pos_x_in;
    logic [POS_W-1:0]  pos_y_in;
    logic [POS_W-1:0]  vel_x_in;
    logic [POS_W-1:0]  vel_y_in;
    logic [CUR_W-1:0]  cursor_x;
    logic [CUR_W-1:0]  cursor_y;
    logic [1:0]        force_mode;
    logic [DT_W-1:0]   time_step;
    logic              last_particle;
    modport source (output valid, active_in, life_left, pos_x_in, pos_y_in, vel_x_in,
        vel_y_in, cursor_x, cursor_y, force_mode, time_step, last_particle, input ready);
    modport sink (input valid, active_in, life_left, pos_x_in, pos_y_in, vel_x_in,
        vel_y_in, cursor_x, cursor_y, force_mode, time_step, last_particle, output ready);
endinterface
`default_nettype wire

// File: src/pas_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pas_out_if;
    import pas_pkg::*;
    logic             valid;
    logic             ready;
    logic             active_out;
    logic             clear_alpha;
    logic [POS_W-1:0] pos_x_out;
    logic [POS_W-1:0] pos_y_out;
    logic [POS_W-1:0] vel_x_out;
    logic [POS_W-1:0] vel_y_out;
    logic             last_out;
    modport source (output valid, active_out, clear_alpha, pos_x_out, pos_y_out,
        vel_x_out, vel_y_out, last_out, input ready);
    modport sink (input valid, active_out, clear_alpha, pos_x_out, pos_y_out,
        vel_x_out, vel_y_out, last_out, output ready);
endinterface
`default_nettype wire

// File: src/pas_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module pas_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pas_pkg::ADDR_W-1:0]  paddr,
    input  logic [pas_pkg::DATA_W-1:0]  pwdata,
    output logic [pas_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output pas_pkg::t_cfg               o_cfg
);
    import pas_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_wr;
    t_reg w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg'(paddr[ADDR_W-1:2]);
    assign o_cfg  = r_cfg;

    // decode the write beat
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_GAIN: n_cfg.gain   = pwdata[GAIN_W-1:0];
                REG_SOFT: n_cfg.soften = pwdata[SOFT_W-1:0];
                REG_DAMP: n_cfg.damp   = pwdata[DAMP_W-1:0];
                default:  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain   <= GAIN_RST;
            r_cfg.soften <= SOFT_RST;
            r_cfg.damp   <= DAMP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            REG_GAIN: prdata = DATA_W'(r_cfg.gain);
            REG_SOFT: prdata = DATA_W'(r_cfg.soften);
            REG_DAMP: prdata = DATA_W'(r_cfg.damp);
            default:  prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

// File: src/pas_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pas_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  pas_pkg::t_item  i_item,
    input  pas_pkg::t_cfg   i_cfg,
    output logic            o_valid,
    output pas_pkg::t_front o_front
);
    import pas_pkg::*;

    logic signed [DIFF_W-1:0] w_dx, w_dy;
    logic [DIFF_W-1:0]        w_ndx, w_ndy;
    t_side                    w_side;

    logic              r_v1, r_v2, r_v3;
    t_side             r_s1, r_s2;
    logic [MAG_W-1:0]  r_mx, r_my;
    logic [GDT_W-1:0]  r_gdt;
    logic [SQ_W-1:0]   r_sqx, r_sqy;
    logic [NUM_W-1:0]  r_nx, r_ny;
    t_front            r_f3;

    // cursor minus position, magnitudes and particle class
    always_comb begin
        w_dx  = $signed({{(DIFF_W-CUR_W-8){1'b0}}, i_item.cursor_x, 8'd0})
              - $signed({{(DIFF_W-POS_W){i_item.pos_x_in[POS_W-1]}}, i_item.pos_x_in});
        w_dy  = $signed({{(DIFF_W-CUR_W-8){1'b0}}, i_item.cursor_y, 8'd0})
              - $signed({{(DIFF_W-POS_W){i_item.pos_y_in[POS_W-1]}}, i_item.pos_y_in});
        w_ndx = -w_dx;
        w_ndy = -w_dy;
        w_side.live = i_item.active_in && (i_item.life_left != '0);
        w_side.clr  = i_item.active_in && (i_item.life_left == '0);
        w_side.frc  = w_side.live && ((i_item.force_mode == MODE_ATTRACT)
                    || (i_item.force_mode == MODE_REPEL));
        w_side.sub  = i_item.force_mode == MODE_REPEL;
        w_side.last = i_item.last_particle;
        w_side.sgnx = w_dx[DIFF_W-1];
        w_side.sgny = w_dy[DIFF_W-1];
        w_side.dt   = i_item.time_step;
        w_side.px   = i_item.pos_x_in;
        w_side.py   = i_item.pos_y_in;
        w_side.vx   = i_item.vel_x_in;
        w_side.vy   = i_item.vel_y_in;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 1: magnitudes and gain times step
    // stage 2: squares and force numerators
    // stage 3: softened denominator, wrapping at 64 bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1      <= w_side;
            r_mx      <= w_dx[DIFF_W-1] ? w_ndx[MAG_W-1:0] : w_dx[MAG_W-1:0];
            r_my      <= w_dy[DIFF_W-1] ? w_ndy[MAG_W-1:0] : w_dy[MAG_W-1:0];
            r_gdt     <= GDT_W'(i_cfg.gain) * GDT_W'(i_item.time_step);
            r_s2      <= r_s1;
            r_sqx     <= SQ_W'(r_mx) * SQ_W'(r_mx);
            r_sqy     <= SQ_W'(r_my) * SQ_W'(r_my);
            r_nx      <= NUM_W'(r_gdt) * NUM_W'(r_mx);
            r_ny      <= NUM_W'(r_gdt) * NUM_W'(r_my);
            r_f3.side <= r_s2;
            r_f3.den  <= r_sqx + r_sqy + {{(SQ_W-SOFT_W-16){1'b0}}, i_cfg.soften, 16'd0};
            r_f3.nx   <= r_nx;
            r_f3.ny   <= r_ny;
        end
    end

    assign o_valid = r_v3;
    assign o_front = r_f3;
endmodule
`default_nettype wire

// File: src/pas_div.sv
`timescale 1ns / 1ps
`default_nettype none
module pas_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  pas_pkg::t_front         i_front,
    output logic                    o_valid,
    output pas_pkg::t_side          o_side,
    output logic [pas_pkg::Q_W-1:0] o_qx,
    output logic [pas_pkg::Q_W-1:0] o_qy
);
    import pas_pkg::*;

    logic                 r_vld  [0:DIV_STEPS];
    t_side                r_side [0:DIV_STEPS];
    logic [SQ_W-1:0]      r_den  [0:DIV_STEPS];
    logic                 r_zero [0:DIV_STEPS];
    logic [SQ_W-1:0]      r_rem  [0:DIV_STEPS][0:1];
    logic [DIV_STEPS-1:0] r_nlo  [0:DIV_STEPS][0:1];
    logic [Q_W-1:0]       r_q    [0:DIV_STEPS][0:1];
    logic                 r_ovf  [0:DIV_STEPS][0:1];
    logic [NUM_W-1:0]     w_num  [0:1];
    logic [Q_W-1:0]       w_qf   [0:1];

    assign w_num[0] = i_front.nx;
    assign w_num[1] = i_front.ny;

    // entry: quotient past 41 bits is flagged up front
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_front.side;
            r_den[0]  <= i_front.den;
            r_zero[0] <= i_front.den == '0;
            for (int a = 0; a < 2; a++) begin
                r_rem[0][a] <= SQ_W'(w_num[a][NUM_W-1:DIV_STEPS]);
                r_nlo[0][a] <= w_num[a][DIV_STEPS-1:0];
                r_q[0][a]   <= '0;
                r_ovf[0][a] <= SQ_W'(w_num[a][NUM_W-1:DIV_STEPS]) >= i_front.den;
            end
        end
    end

    // one restoring step per stage, one quotient bit each
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [SQ_W:0] w_try [0:1];
        logic          w_ge  [0:1];

        always_comb begin
            for (int a = 0; a < 2; a++) begin
                w_try[a] = {r_rem[k-1][a], r_nlo[k-1][a][DIV_STEPS-k]};
                w_ge[a]  = w_try[a] >= {1'b0, r_den[k-1]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= r_side[k-1];
                r_den[k]  <= r_den[k-1];
                r_zero[k] <= r_zero[k-1];
                for (int a = 0; a < 2; a++) begin
                    r_rem[k][a] <= w_ge[a] ? SQ_W'(w_try[a] - {1'b0, r_den[k-1]})
                                           : w_try[a][SQ_W-1:0];
                    r_nlo[k][a] <= r_nlo[k-1][a];
                    r_q[k][a]   <= {r_q[k-1][a][Q_W-2:0], w_ge[a]};
                    r_ovf[k][a] <= r_ovf[k-1][a];
                end
            end
        end
    end

    // clamp at 2^40, zero force on a zero denominator
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            if (r_zero[DIV_STEPS]) begin
                w_qf[a] = '0;
            end else if (r_ovf[DIV_STEPS][a] || (r_q[DIV_STEPS][a][Q_W-1]
                         && (r_q[DIV_STEPS][a][Q_W-2:0] != '0))) begin
                w_qf[a] = {1'b1, {(Q_W-1){1'b0}}};
            end else begin
                w_qf[a] = r_q[DIV_STEPS][a];
            end
        end
    end

    assign o_valid = r_vld[DIV_STEPS];
    assign o_side  = r_side[DIV_STEPS];
    assign o_qx    = w_qf[0];
    assign o_qy    = w_qf[1];
endmodule
`default_nettype wire

// File: src/pas_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pas_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  pas_pkg::t_side          i_side,
    input  logic [pas_pkg::Q_W-1:0] i_qx,
    input  logic [pas_pkg::Q_W-1:0] i_qy,
    input  pas_pkg::t_cfg           i_cfg,
    output logic                    o_valid,
    output pas_pkg::t_result        o_res
);
    import pas_pkg::*;

    localparam int SUM_W = Q_W + 2;

    // clamp a wide signed sum into 32 bits
    function automatic logic [POS_W-1:0] sat32(input logic [SUM_W-1:0] v);
        logic [POS_W-1:0] r;
        if (v[SUM_W-1:POS_W-1] == '0 || v[SUM_W-1:POS_W-1] == '1) begin
            r = v[POS_W-1:0];
        end else if (v[SUM_W-1]) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

    // signed value times unsigned Q0.16, rounded half up on the magnitude
    function automatic logic [POS_W-1:0] scale_q16(input logic [POS_W-1:0] v,
                                                   input logic [DT_W-1:0] f);
        logic [POS_W-1:0]      mag;
        logic [POS_W+DT_W-1:0] prod;
        logic [POS_W-1:0]      r;
        mag  = v[POS_W-1] ? POS_W'(-v) : v;
        prod = (POS_W+DT_W)'(mag) * (POS_W+DT_W)'(f) + (POS_W+DT_W)'(32768);
        r    = prod[POS_W+DT_W-1:DT_W];
        return v[POS_W-1] ? POS_W'(-r) : r;
    endfunction

    function automatic logic [POS_W-1:0] apply_dv(input logic [POS_W-1:0] v,
                                                  input logic [Q_W-1:0] q,
                                                  input logic sgn,
                                                  input logic sub);
        logic [SUM_W-1:0] vw;
        logic [SUM_W-1:0] dv;
        vw = {{(SUM_W-POS_W){v[POS_W-1]}}, v};
        dv = (sgn ^ sub) ? SUM_W'(-{2'b00, q}) : {2'b00, q};
        return sat32(vw + dv);
    endfunction

    logic             r_v1, r_v2, r_v3;
    t_side            r_s1, r_s2;
    logic [POS_W-1:0] r_vx1, r_vy1, r_vx2, r_vy2;
    t_result          r_res;
    logic [POS_W-1:0] w_dpx, w_dpy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign w_dpx = scale_q16(r_vx2, r_s2.dt);
    assign w_dpy = scale_q16(r_vy2, r_s2.dt);

    // stage 1: apply force, stage 2: damp, stage 3: advance position
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1  <= i_side;
            r_vx1 <= i_side.frc ? apply_dv(i_side.vx, i_qx, i_side.sgnx, i_side.sub)
                                : i_side.vx;
            r_vy1 <= i_side.frc ? apply_dv(i_side.vy, i_qy, i_side.sgny, i_side.sub)
                                : i_side.vy;
            r_s2  <= r_s1;
            r_vx2 <= r_s1.live ? scale_q16(r_vx1, i_cfg.damp) : r_vx1;
            r_vy2 <= r_s1.live ? scale_q16(r_vy1, i_cfg.damp) : r_vy1;
            r_res.active_out  <= r_s2.live;
            r_res.clear_alpha <= r_s2.clr;
            r_res.last_out    <= r_s2.last;
            r_res.vel_x_out   <= r_vx2;
            r_res.vel_y_out   <= r_vy2;
            r_res.pos_x_out   <= r_s2.live
                ? sat32(SUM_W'($signed(r_s2.px)) + SUM_W'($signed(w_dpx))) : r_s2.px;
            r_res.pos_y_out   <= r_s2.live
                ? sat32(SUM_W'($signed(r_s2.py)) + SUM_W'($signed(w_dpy))) : r_s2.py;
        end
    end

    assign o_valid = r_v3;
    assign o_res   = r_res;
endmodule
`default_nettype wire

// File: src/particle_attractor_step_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Particle attractor step: one particle in, one particle out, one beat per clock.
// Each particle takes a softened inverse-distance force, toward or away from the cursor, is damped
// and advanced by one Euler step; expired particles come out inactive with
// clear_alpha set, inactive ones pass through. Three stages form the distance
// terms and the force numerator, the divider takes an entry stage plus 41
// restoring stages that give one quotient bit each, and three stages apply
// force, damping and the position update. Throughput is one particle per cycle;
// the whole pipe holds while the output beat waits, and nothing is dropped or
// repeated. Registers: force_gain at 0x0, softening at 0x4, damping at 0x8.
module particle_attractor_step_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pas_in_if.sink                      i_in,
    pas_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pas_pkg::ADDR_W-1:0]  paddr,
    input  logic [pas_pkg::DATA_W-1:0]  pwdata,
    output logic [pas_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import pas_pkg::*;

    t_cfg             w_cfg;
    t_item            w_item;
    t_front           w_front;
    t_side            w_side;
    t_result          w_res;
    logic             w_en, w_fv, w_dv, w_ov;
    logic [Q_W-1:0]   w_qx, w_qy;

    // advance the pipe whenever the output beat is free or taken
    assign w_en       = !w_ov || o_out.ready;
    assign i_in.ready = w_en;

    assign w_item.active_in     = i_in.active_in;
    assign w_item.life_left     = i_in.life_left;
    assign w_item.pos_x_in      = i_in.pos_x_in;
    assign w_item.pos_y_in      = i_in.pos_y_in;
    assign w_item.vel_x_in      = i_in.vel_x_in;
    assign w_item.vel_y_in      = i_in.vel_y_in;
    assign w_item.cursor_x      = i_in.cursor_x;
    assign w_item.cursor_y      = i_in.cursor_y;
    assign w_item.force_mode    = i_in.force_mode;
    assign w_item.time_step     = i_in.time_step;
    assign w_item.last_particle = i_in.last_particle;

    pas_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cfg(w_cfg)
    );

    pas_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_in.valid),
        .i_item(w_item), .i_cfg(w_cfg), .o_valid(w_fv), .o_front(w_front)
    );

    pas_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_fv),
        .i_front(w_front), .o_valid(w_dv), .o_side(w_side), .o_qx(w_qx), .o_qy(w_qy)
    );

    pas_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_dv),
        .i_side(w_side), .i_qx(w_qx), .i_qy(w_qy), .i_cfg(w_cfg),
        .o_valid(w_ov), .o_res(w_res)
    );

    assign o_out.valid       = w_ov;
    assign o_out.active_out  = w_res.active_out;
    assign o_out.clear_alpha = w_res.clear_alpha;
    assign o_out.pos_x_out   = w_res.pos_x_out;
    assign o_out.pos_y_out   = w_res.pos_y_out;
    assign o_out.vel_x_out   = w_res.vel_x_out;
    assign o_out.vel_y_out   = w_res.vel_y_out;
    assign o_out.last_out    = w_res.last_out;
endmodule
`default_nettype wire

// File: src/pas_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "particle_attractor_step_core_assert.svh"
module pas_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_out_active,
    input logic                       i_out_clear,
    input logic [pas_pkg::POS_W-1:0]  i_out_pos_x
);
    // hold the beat while the sink stalls
    `PAS_ASSERT_NEXT(a_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_pos_x))
    // an expired particle never leaves alive
    `PAS_ASSERT_SAME(a_clear, i_out_valid && i_out_clear, !i_out_active)
    // reset empties the pipe
    `PAS_ASSERT_RST(a_rst, !i_rst_n, !i_out_valid)
endmodule

bind particle_attractor_step_core pas_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready), .i_out_active(o_out.active_out),
    .i_out_clear(o_out.clear_alpha), .i_out_pos_x(o_out.pos_x_out)
);
`default_nettype wire
